/* src/dv64_pkg.sv */
// ============================================================================
// dv64_pkg
// Shared types and constants for the pipelined 64-bit divider.
// ============================================================================
`default_nettype none

package dv64_pkg;

  // Operand and result width.
  localparam int unsigned DATA_W = 64;

  // One quotient bit is settled per iteration stage.
  localparam int unsigned STEP_COUNT = DATA_W;

  // Sign bit of a two's complement operand.
  localparam logic [DATA_W-1:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  // Operation codes.
  localparam logic OP_UNSIGNED = 1'b0;
  localparam logic OP_SIGNED   = 1'b1;

  // Word carried down the pipeline from one stage to the next.
  typedef struct packed {
    logic              valid;  // stage holds a live word
    logic              op;     // operation code
    logic              neg;    // quotient must be negated at the end
    logic              dz;     // divisor was zero
    logic [DATA_W-1:0] rem;    // partial remainder, below the divisor unless the divisor is zero
    logic [DATA_W-1:0] quo;    // dividend bits still to shift out, quotient bits shifted in
    logic [DATA_W-1:0] dvs;    // divisor magnitude
  } dv_stage_t;

endpackage

`default_nettype wire

/* src/divider_64bit_signed_unsigned.sv */
// Pipeline: an accepted input word passes through one input stage, 64 restoring
//   iteration stages and one output stage on its way to its result word.
// Throughput: one word per cycle while the output is not stalled; each iteration stage owns one 66-bit subtractor.
// A stalled output word freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears every stage valid bit; data is not reset.
// ============================================================================
// divider_64bit_signed_unsigned
// Pipelined 64-bit restoring divider with unsigned quotient and remainder,
// signed quotient, and a divide-by-zero flag.
// ============================================================================
`default_nettype none

module divider_64bit_signed_unsigned import dv64_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_op,
  input  wire logic [DATA_W-1:0] in_dividend,
  input  wire logic [DATA_W-1:0] in_divisor,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [DATA_W-1:0]      out_quotient,
  output logic [DATA_W-1:0]      out_remainder,
  output logic                   out_divide_by_zero
);

  dv_stage_t st [STEP_COUNT+1];
  logic      adv;

  // Input is held off whenever the pipeline is frozen.
  assign in_stall = !adv;

  dv64_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_op       (in_op),
    .in_dividend (in_dividend),
    .in_divisor  (in_divisor),
    .st_o        (st[0])
  );

  // One stage per quotient bit, most significant first.
  for (genvar i = 0; i < STEP_COUNT; i++) begin : g_step
    dv64_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .st_i  (st[i]),
      .st_o  (st[i+1])
    );
  end

  dv64_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .st_i               (st[STEP_COUNT]),
    .adv                (adv),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero)
  );

endmodule

`default_nettype wire

/* src/dv64_front.sv */
// ============================================================================
// dv64_front
// Input stage: takes operand magnitudes, records the quotient sign and flags
// a zero divisor, then registers the word for the iteration stages.
// ============================================================================
`default_nettype none

module dv64_front import dv64_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic              in_op,
  input  wire logic [DATA_W-1:0] in_dividend,
  input  wire logic [DATA_W-1:0] in_divisor,
  output dv_stage_t              st_o
);

  dv_stage_t st_r;
  dv_stage_t st_nxt;
  logic      n_neg;
  logic      d_neg;

  // Signed mode works on magnitudes; unsigned mode passes the operands through.
  always_comb begin
    n_neg          = (in_op == OP_SIGNED) && ((in_dividend & SIGN_BIT) != '0);
    d_neg          = (in_op == OP_SIGNED) && ((in_divisor & SIGN_BIT) != '0);
    st_nxt.valid   = in_valid;
    st_nxt.op      = in_op;
    st_nxt.neg     = n_neg ^ d_neg;
    st_nxt.dz      = (in_divisor == '0);
    st_nxt.rem     = '0;
    st_nxt.quo     = n_neg ? ('0 - in_dividend) : in_dividend;
    st_nxt.dvs     = d_neg ? ('0 - in_divisor) : in_divisor;
  end

  // Stage register; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

`default_nettype wire

/* src/dv64_step.sv */
// ============================================================================
// dv64_step
// One restoring division iteration: shifts the next dividend bit into the
// partial remainder, trial-subtracts the divisor and settles one quotient bit.
// ============================================================================
`default_nettype none

module dv64_step import dv64_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire dv_stage_t st_i,
  output dv_stage_t      st_o
);

  dv_stage_t         st_r;
  dv_stage_t         st_nxt;
  logic [DATA_W:0]   part;
  logic [DATA_W+1:0] diff;
  logic              borrow;

  // Trial subtraction; the remainder is restored when it borrows.
  always_comb begin
    part   = {st_i.rem, st_i.quo[DATA_W-1]};
    diff   = {1'b0, part} - {2'b00, st_i.dvs};
    borrow = diff[DATA_W+1];
    st_nxt = st_i;
    st_nxt.rem = borrow ? part[DATA_W-1:0] : diff[DATA_W-1:0];
    st_nxt.quo = {st_i.quo[DATA_W-2:0], ~borrow};
  end

  // Stage register; only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

`default_nettype wire

/* src/dv64_back.sv */
// ============================================================================
// dv64_back
// Output stage: applies the quotient sign, forces the zero-divisor and
// signed-mode results, and holds the result word until it is taken.
// ============================================================================
`default_nettype none

module dv64_back import dv64_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dv_stage_t          st_i,
  output logic                    adv,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [DATA_W-1:0]       out_quotient,
  output logic [DATA_W-1:0]       out_remainder,
  output logic                    out_divide_by_zero
);

  logic              out_valid_r;
  logic [DATA_W-1:0] quotient_r;
  logic [DATA_W-1:0] remainder_r;
  logic              dz_r;
  logic [DATA_W-1:0] quotient_nxt;
  logic [DATA_W-1:0] remainder_nxt;

  // The whole pipeline moves unless a finished word waits on a stalled output.
  assign adv = !(out_valid_r && out_stall);

  // Final result selection.
  always_comb begin
    if (st_i.dz) begin
      quotient_nxt  = '0;
      remainder_nxt = '0;
    end else if (st_i.op == OP_SIGNED) begin
      quotient_nxt  = st_i.neg ? ('0 - st_i.quo) : st_i.quo;
      remainder_nxt = '0;
    end else begin
      quotient_nxt  = st_i.quo;
      remainder_nxt = st_i.rem;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_i.valid;
    end
  end

  // Output payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      quotient_r  <= quotient_nxt;
      remainder_r <= remainder_nxt;
      dz_r        <= st_i.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = quotient_r;
  assign out_remainder      = remainder_r;
  assign out_divide_by_zero = dz_r;

  // An unsigned remainder must end below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_i.valid && !st_i.dz && (st_i.op == OP_UNSIGNED))
      |=> (out_remainder < $past(st_i.dvs)))
    else $error("remainder not below divisor");

  // A zero divisor gives zero results and raises the flag.
  a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_i.valid && st_i.dz)
      |=> (out_divide_by_zero && (out_quotient == '0) && (out_remainder == '0)))
    else $error("zero divisor result not cleared");

  // Signed mode reports no remainder.
  a_signed_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && st_i.valid && (st_i.op == OP_SIGNED)) |=> (out_remainder == '0))
    else $error("signed mode remainder not zero");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

/* bench/divider_64bit_signed_unsigned_tb.sv */
// ----------------------------------------------------------------------------
// Testbench for divider_64bit_signed_unsigned
// Drives dividend/divisor words through the pipelined divider, predicts the
// quotient, remainder and divide-by-zero flag of every accepted word, and
// checks each result word against the oldest prediction. It covers corner
// operands, random unsigned, signed and mixed traffic, and pipeline drains.
// ----------------------------------------------------------------------------
`default_nettype none

module divider_64bit_signed_unsigned_tb import dv64_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PIPE_LATENCY   = 66;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] MAX_POS  = SIGN_BIT - 1;

  // One predicted result word.
  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
  } division_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_op;
  logic [DATA_W-1:0] in_dividend;
  logic [DATA_W-1:0] in_divisor;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_quotient;
  logic [DATA_W-1:0] out_remainder;
  logic              out_divide_by_zero;

  division_t   pending_divisions[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;

  divider_64bit_signed_unsigned dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_dividend       (in_dividend),
    .in_divisor        (in_divisor),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_quotient      (out_quotient),
    .out_remainder     (out_remainder),
    .out_divide_by_zero(out_divide_by_zero)
  );

  // Free-running 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predicted result of one division word.
  function automatic division_t divide_words(logic op, logic [DATA_W-1:0] dividend,
                                             logic [DATA_W-1:0] divisor);
    division_t         res;
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W-1:0] mag_q;
    res = '0;
    if (divisor == '0) begin
      res.divide_by_zero = 1'b1;
    end else if (op == OP_UNSIGNED) begin
      res.quotient  = dividend / divisor;
      res.remainder = dividend % divisor;
    end else begin
      // Divide magnitudes, then fix the sign; the most negative value wraps.
      mag_n = dividend[DATA_W-1] ? -dividend : dividend;
      mag_d = divisor[DATA_W-1] ? -divisor : divisor;
      mag_q = mag_n / mag_d;
      res.quotient = (dividend[DATA_W-1] ^ divisor[DATA_W-1]) ? -mag_q : mag_q;
    end
    return res;
  endfunction

  // Random operand of random bit length, sometimes negated, so that quotients
  // of every size show up.
  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] v;
    int unsigned       bits;
    v    = {$urandom, $urandom};
    bits = $urandom_range(1, DATA_W);
    if (bits < DATA_W) begin
      v = v & ((64'd1 << bits) - 1);
    end
    if ($urandom_range(0, 3) == 0) begin
      v = -v;
    end
    return v;
  endfunction

  // Drop the input valid for a number of cycles.
  task automatic hold_off(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Send one word and record its prediction once it is accepted.
  task automatic send_word(logic op, logic [DATA_W-1:0] dividend,
                           logic [DATA_W-1:0] divisor);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      hold_off($urandom_range(1, 5));
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_op       <= op;
    in_dividend <= dividend;
    in_divisor  <= divisor;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_divisions.push_back(divide_words(op, dividend, divisor));
  endtask

  // Send a random word of the given operation, sometimes with a zero divisor.
  task automatic send_random(logic op);
    logic [DATA_W-1:0] divisor;
    divisor = random_operand();
    if ($urandom_range(0, 31) == 0) begin
      divisor = '0;
    end
    send_word(op, random_operand(), divisor);
  endtask

  // Corner operands and every special case.
  task automatic test_corner_operands();
    gap_pct   = 20;
    stall_pct = 20;
    send_word(OP_UNSIGNED, '0, '0);
    send_word(OP_SIGNED, 64'd123, '0);
    send_word(OP_SIGNED, SIGN_BIT, '0);
    send_word(OP_UNSIGNED, ALL_ONES, ALL_ONES);
    send_word(OP_UNSIGNED, ALL_ONES, 64'd1);
    send_word(OP_UNSIGNED, 64'd1, ALL_ONES);
    send_word(OP_UNSIGNED, '0, 64'd5);
    send_word(OP_UNSIGNED, ALL_ONES, SIGN_BIT);
    send_word(OP_UNSIGNED, 64'd1000, 64'd7);
    send_word(OP_UNSIGNED, 64'd7, 64'd1000);
    send_word(OP_UNSIGNED, MAX_POS, 64'd3);
    send_word(OP_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_word(OP_SIGNED, SIGN_BIT, ALL_ONES);
    send_word(OP_SIGNED, SIGN_BIT, 64'd1);
    send_word(OP_SIGNED, SIGN_BIT, SIGN_BIT);
    send_word(OP_SIGNED, ALL_ONES, ALL_ONES);
    send_word(OP_SIGNED, -64'd7, 64'd2);
    send_word(OP_SIGNED, 64'd7, -64'd2);
    send_word(OP_SIGNED, -64'd7, -64'd2);
    send_word(OP_SIGNED, MAX_POS, ALL_ONES);
    send_word(OP_SIGNED, 64'd1, SIGN_BIT);
    send_word(OP_SIGNED, '0, ALL_ONES);
    send_word(OP_SIGNED, MAX_POS, MAX_POS);
  endtask

  // Random unsigned divisions.
  task automatic test_random_unsigned();
    gap_pct   = 30;
    stall_pct = 10;
    repeat (350) send_random(OP_UNSIGNED);
  endtask

  // Random signed divisions; the first half runs without any idling.
  task automatic test_random_signed();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (175) send_random(OP_SIGNED);
    gap_pct   = 10;
    stall_pct = 40;
    repeat (175) send_random(OP_SIGNED);
  endtask

  // Send two bursts of 50 random words, letting the pipeline drain completely after each.
  task automatic test_pipeline_drain();
    gap_pct   = 15;
    stall_pct = 25;
    repeat (2) begin
      repeat (50) send_random(logic'($urandom_range(0, 1)));
      hold_off(1);
      while (pending_divisions.size() != 0) @(posedge clk);
    end
  endtask

  // Mixed operations back to back with no idling on either side.
  task automatic test_back_to_back();
    gap_pct   = 0;
    stall_pct = 0;
    repeat (330) send_random(logic'($urandom_range(0, 1)));
  endtask

  // Receiver stall bursts, started at random at the rate set by stall_pct.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left != 0) begin
        out_stall  <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    division_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_divisions.size() == 0) begin
        $error("unexpected result word: quotient %h remainder %h divide_by_zero %b",
               out_quotient, out_remainder, out_divide_by_zero);
        mismatch_count++;
      end else begin
        exp_word = pending_divisions.pop_front();
        if (out_quotient !== exp_word.quotient) begin
          $error("quotient: expected %h, got %h", exp_word.quotient, out_quotient);
          mismatch_count++;
        end
        if (out_remainder !== exp_word.remainder) begin
          $error("remainder: expected %h, got %h", exp_word.remainder, out_remainder);
          mismatch_count++;
        end
        if (out_divide_by_zero !== exp_word.divide_by_zero) begin
          $error("divide_by_zero: expected %b, got %b",
                 exp_word.divide_by_zero, out_divide_by_zero);
          mismatch_count++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: end the run when the divider stops moving words.
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_UNSIGNED;
    in_dividend    = '0;
    in_divisor     = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    gap_pct        = 0;
    stall_pct      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_operands();
    test_random_unsigned();
    test_random_signed();
    test_pipeline_drain();
    test_back_to_back();

    // Wait for every outstanding result, then watch for stray words.
    hold_off(1);
    while (pending_divisions.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* divider_64bit_signed_unsigned.f */
src/dv64_pkg.sv
src/dv64_front.sv
src/dv64_step.sv
src/dv64_back.sv
src/divider_64bit_signed_unsigned.sv
bench/divider_64bit_signed_unsigned_tb.sv
